// ===== hdl/triangle_unit_normal_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the triangle unit normal block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define TUN_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Consequent holds in the cycle after the antecedent.
`define TUN_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define TUN_ASSERT(name, clk, rst_n, prop)
`define TUN_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/tun_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tun_pkg
// Widths, defaults and sideband types for the triangle unit normal block.
// ---------------------------------------------------------------------------
package tun_pkg;

  localparam int unsigned COORD_WIDTH_DEF      = 32;
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;

  localparam int unsigned IN_W      = 32;  // coordinate port width
  localparam int unsigned EDGE_W    = 33;  // exact edge component
  localparam int unsigned MAG_W     = 33;  // edge magnitude
  localparam int unsigned PROD_W    = 64;  // product magnitude, kept mod 2^64
  localparam int unsigned DIFF_W    = 67;  // signed cross component
  localparam int unsigned NMAG_W    = 65;  // cross component magnitude
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned MANT_BITS = 24;
  localparam int unsigned SQ_W      = 48;
  localparam int unsigned SUM_W     = 50;
  localparam int unsigned T_W       = 5;
  localparam int unsigned RAD_W     = 62;
  localparam int unsigned RAD_MIN_LEN = 61; // radicand is scaled to at least 2^60
  localparam int unsigned SQRT_ITER = 32;
  localparam int unsigned SQRT_W    = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned MT_W      = 31;
  localparam int unsigned OUT_W     = 16;
  localparam logic [OUT_W-1:0] OUT_MAX = 16'd32767;

  typedef struct packed {
    logic [2:0] neg;   // sign of each cross component
    logic       dg;    // zero cross product
    logic       last;
  } tun_side_t;

  typedef struct packed {
    logic [2:0][MT_W-1:0] mt;   // scaled mantissas
    tun_side_t            side;
  } tun_sq_side_t;

endpackage

// ===== hdl/triangle_unit_normal.sv =====
`timescale 1ns / 1ps
// Pipeline from input transaction to result: ten front stages, 32 square-root
//   stages, NORMAL_FRAC_BITS+1 divider stages, output reg.
// Throughput: one triangle per cycle; the whole pipeline advances together and holds
//   only while a finished result waits on out_ready_i.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are not reset.
// ---------------------------------------------------------------------------
// triangle_unit_normal
// Face normal of a triangle: edge vectors, cross product (products kept mod 2^64),
// then scaling to unit length in signed fixed point with a pipelined sqrt and divider.
// ---------------------------------------------------------------------------
module triangle_unit_normal #(
  parameter int unsigned COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
  parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tun_pkg::IN_W-1:0]      v0_x_i,
  input  logic [tun_pkg::IN_W-1:0]      v0_y_i,
  input  logic [tun_pkg::IN_W-1:0]      v0_z_i,
  input  logic [tun_pkg::IN_W-1:0]      v1_x_i,
  input  logic [tun_pkg::IN_W-1:0]      v1_y_i,
  input  logic [tun_pkg::IN_W-1:0]      v1_z_i,
  input  logic [tun_pkg::IN_W-1:0]      v2_x_i,
  input  logic [tun_pkg::IN_W-1:0]      v2_y_i,
  input  logic [tun_pkg::IN_W-1:0]      v2_z_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [tun_pkg::OUT_W-1:0] normal_x_o,
  output logic signed [tun_pkg::OUT_W-1:0] normal_y_o,
  output logic signed [tun_pkg::OUT_W-1:0] normal_z_o,
  output logic                          degenerate_o,
  output logic                          last_out_o
);
  import tun_pkg::*;

  `include "triangle_unit_normal_assert.svh"

  localparam int unsigned QW = NORMAL_FRAC_BITS + 1;

  // Global advance: every stage moves when the output register is free or being drained.
  logic en;
  logic out_valid_q;
  assign en         = out_ready_i | ~out_valid_q;
  assign in_ready_o = en;

  // Bit length of a magnitude (0 for zero).
  function automatic logic [LEN_W-1:0] bitlen(input logic [NMAG_W-1:0] v);
    logic [LEN_W-1:0] l;
    l = '0;
    for (int i = 0; i < NMAG_W; i++) begin
      if (v[i]) l = LEN_W'(i + 1);
    end
    return l;
  endfunction

  function automatic logic [EDGE_W-1:0] sext(input logic [IN_W-1:0] x);
    return EDGE_W'($signed(x[COORD_WIDTH-1:0]));
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic [EDGE_W-1:0] x);
    return x[EDGE_W-1] ? MAG_W'(-x) : x;
  endfunction

  // ---------------- stage 1: edges ----------------
  logic [IN_W-1:0]   vin [9];
  logic [EDGE_W-1:0] ea_d [3], eb_d [3];
  logic [EDGE_W-1:0] ea_q [3], eb_q [3];
  logic              s1_v_q, s1_last_q;

  assign vin[0] = v0_x_i;  assign vin[1] = v0_y_i;  assign vin[2] = v0_z_i;
  assign vin[3] = v1_x_i;  assign vin[4] = v1_y_i;  assign vin[5] = v1_z_i;
  assign vin[6] = v2_x_i;  assign vin[7] = v2_y_i;  assign vin[8] = v2_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea_d[i] = sext(vin[3+i]) - sext(vin[i]);
      eb_d[i] = sext(vin[6+i]) - sext(vin[i]);
    end
  end

  // ---------------- stage 2: partial products ----------------
  // Six products in the order a1*b2, a2*b1, a2*b0, a0*b2, a0*b1, a1*b0.
  // 33x33 magnitude product kept mod 2^64: low 32x32 product plus cross terms.
  logic [EDGE_W-1:0] pa [6], pb [6];
  logic [PROD_W-1:0] pl_q [6];
  logic [31:0]       cr_q [6];
  logic [5:0]        sg_q;
  logic              s2_v_q, s2_last_q;

  always_comb begin
    pa[0] = ea_q[1]; pb[0] = eb_q[2];
    pa[1] = ea_q[2]; pb[1] = eb_q[1];
    pa[2] = ea_q[2]; pb[2] = eb_q[0];
    pa[3] = ea_q[0]; pb[3] = eb_q[2];
    pa[4] = ea_q[0]; pb[4] = eb_q[1];
    pa[5] = ea_q[1]; pb[5] = eb_q[0];
  end

  // ---------------- stage 3: product magnitudes ----------------
  logic [PROD_W-1:0] lo_q [6];
  logic [5:0]        pn_q;
  logic              s3_v_q, s3_last_q;

  // ---------------- stage 4: cross components ----------------
  logic [NMAG_W-1:0] nm_d [3], nm_q [3];
  logic [2:0]        nn_d, nn_q;
  logic              s4_v_q, s4_last_q;

  always_comb begin
    logic signed [DIFF_W-1:0] sx, sy, df;
    for (int c = 0; c < 3; c++) begin
      sx = pn_q[2*c]   ? -$signed(DIFF_W'(lo_q[2*c]))   : $signed(DIFF_W'(lo_q[2*c]));
      sy = pn_q[2*c+1] ? -$signed(DIFF_W'(lo_q[2*c+1])) : $signed(DIFF_W'(lo_q[2*c+1]));
      df = sx - sy;
      nn_d[c] = df[DIFF_W-1];
      nm_d[c] = df[DIFF_W-1] ? NMAG_W'(-df) : NMAG_W'(df);
    end
  end

  // ---------------- stage 5: normalizing shift ----------------
  logic [LEN_W-1:0]  len5;
  logic [NMAG_W-1:0] nm5_q [3];
  logic [LEN_W-1:0]  k5_q;
  tun_side_t         sd5_q;
  logic              s5_v_q;

  assign len5 = bitlen(nm_q[0] | nm_q[1] | nm_q[2]);

  // ---------------- stages 6-10: mantissas, sum of squares, scaling ----------------
  logic [MANT_BITS-1:0] m6_q [3], m7_q [3], m8_q [3], m9_q [3];
  logic [SQ_W-1:0]      sq7_q [3];
  logic [SUM_W-1:0]     s8_q, s9_q;
  logic [T_W-1:0]       t9_q;
  logic [RAD_W-1:0]     rad10_q;
  tun_sq_side_t         sq10_q;
  tun_side_t            sd6_q, sd7_q, sd8_q, sd9_q;
  logic                 s6_v_q, s7_v_q, s8_v_q, s9_v_q, s10_v_q;
  logic [LEN_W-1:0]     len9;
  logic [LEN_W-1:0]     tdiff9;

  assign len9   = bitlen(NMAG_W'(s8_q));
  assign tdiff9 = LEN_W'(RAD_MIN_LEN + 1) - len9;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      s6_v_q  <= 1'b0;
      s7_v_q  <= 1'b0;
      s8_v_q  <= 1'b0;
      s9_v_q  <= 1'b0;
      s10_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      s6_v_q  <= s5_v_q;
      s7_v_q  <= s6_v_q;
      s8_v_q  <= s7_v_q;
      s9_v_q  <= s8_v_q;
      s10_v_q <= s9_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      ea_q      <= ea_d;
      eb_q      <= eb_d;
      s1_last_q <= last_in_i;
      // stage 2
      for (int p = 0; p < 6; p++) begin
        logic [MAG_W-1:0] ma, mb;
        ma = mag(pa[p]);
        mb = mag(pb[p]);
        pl_q[p] <= ma[31:0] * mb[31:0];
        cr_q[p] <= (ma[32] ? mb[31:0] : 32'd0) + (mb[32] ? ma[31:0] : 32'd0);
        sg_q[p] <= pa[p][EDGE_W-1] ^ pb[p][EDGE_W-1];
      end
      s2_last_q <= s1_last_q;
      // stage 3
      for (int p = 0; p < 6; p++) begin
        logic [PROD_W-1:0] lo;
        lo = pl_q[p] + {cr_q[p], 32'd0};
        lo_q[p] <= lo;
        pn_q[p] <= sg_q[p] && (lo != '0);
      end
      s3_last_q <= s2_last_q;
      // stage 4
      nm_q      <= nm_d;
      nn_q      <= nn_d;
      s4_last_q <= s3_last_q;
      // stage 5: keep the top MANT_BITS of the largest component
      nm5_q      <= nm_q;
      k5_q       <= (len5 > LEN_W'(MANT_BITS)) ? len5 - LEN_W'(MANT_BITS) : '0;
      sd5_q.neg  <= nn_q;
      sd5_q.dg   <= (len5 == '0);
      sd5_q.last <= s4_last_q;
      // stage 6
      for (int i = 0; i < 3; i++) m6_q[i] <= MANT_BITS'(nm5_q[i] >> k5_q);
      sd6_q <= sd5_q;
      // stage 7
      for (int i = 0; i < 3; i++) sq7_q[i] <= SQ_W'(m6_q[i]) * SQ_W'(m6_q[i]);
      m7_q  <= m6_q;
      sd7_q <= sd6_q;
      // stage 8
      s8_q  <= SUM_W'(sq7_q[0]) + SUM_W'(sq7_q[1]) + SUM_W'(sq7_q[2]);
      m8_q  <= m7_q;
      sd8_q <= sd7_q;
      // stage 9: number of two-bit steps that lift the sum to 2^60 or more
      t9_q  <= T_W'(tdiff9 >> 1);
      s9_q  <= s8_q;
      m9_q  <= m8_q;
      sd9_q <= sd8_q;
      // stage 10
      rad10_q <= RAD_W'(s9_q) << {t9_q, 1'b0};
      for (int i = 0; i < 3; i++) sq10_q.mt[i] <= MT_W'(m9_q[i]) << t9_q;
      sq10_q.side <= sd9_q;
    end
  end

  // ---------------- square root ----------------
  logic               sq_v;
  logic [ROOT_W-1:0]  root;
  tun_sq_side_t       sq_sb;

  tun_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s10_v_q),
    .rad_i  (rad10_q),
    .sb_i   (sq10_q),
    .vld_o  (sq_v),
    .root_o (root),
    .sb_o   (sq_sb)
  );

  // ---------------- divide ----------------
  logic               dv_v;
  logic [2:0][QW-1:0] quo;
  tun_side_t          dv_sb;

  tun_div #(
    .QW (QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_v),
    .mt_i   (sq_sb.mt),
    .root_i (root),
    .sb_i   (sq_sb.side),
    .vld_o  (dv_v),
    .quo_o  (quo),
    .sb_o   (dv_sb)
  );

  // ---------------- output register: saturate, sign, degenerate ----------------
  logic [OUT_W-1:0] res_d [3];
  logic [OUT_W-1:0] res_q [3];
  logic             dg_q, last_q;

  always_comb begin
    logic [31:0]      qx;
    logic [OUT_W-1:0] mv;
    for (int i = 0; i < 3; i++) begin
      qx = 32'(quo[i]);
      mv = (qx > 32'(OUT_MAX)) ? OUT_MAX : qx[OUT_W-1:0];
      if (dv_sb.dg) begin
        res_d[i] = '0;
      end else if (dv_sb.neg[i]) begin
        res_d[i] = -mv;
      end else begin
        res_d[i] = mv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      dg_q   <= dv_sb.dg;
      last_q <= dv_sb.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = res_q[0];
  assign normal_y_o   = res_q[1];
  assign normal_z_o   = res_q[2];
  assign degenerate_o = dg_q;
  assign last_out_o   = last_q;

  // ---------------- checks ----------------
  `TUN_ASSERT(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o |-> (normal_x_o == '0) && (normal_y_o == '0) && (normal_z_o == '0))
  `TUN_ASSERT(a_normal_nonzero, clk_i, rst_ni, out_valid_o && !degenerate_o |-> (normal_x_o != '0) || (normal_y_o != '0) || (normal_z_o != '0))
  `TUN_ASSERT(a_stall_only_full, clk_i, rst_ni, !in_ready_o |-> out_valid_o)
  `TUN_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !in_ready_o, $stable(s10_v_q) && $stable(rad10_q))

endmodule

// ===== hdl/tun_sqrt.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tun_sqrt
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module tun_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  vld_i,
  input  logic [tun_pkg::RAD_W-1:0]  rad_i,
  input  tun_pkg::tun_sq_side_t sb_i,
  output logic                  vld_o,
  output logic [tun_pkg::ROOT_W-1:0] root_o,
  output tun_pkg::tun_sq_side_t sb_o
);
  import tun_pkg::*;

  logic [SQRT_W-1:0]  n_q  [SQRT_ITER];
  logic [SQRT_W-1:0]  r_q  [SQRT_ITER];
  tun_sq_side_t       sb_q [SQRT_ITER];
  logic [SQRT_ITER-1:0] v_q;

  for (genvar j = 0; j < SQRT_ITER; j++) begin : g_stage
    logic [SQRT_W-1:0] n_in, r_in, bt, trial, n_d, r_d;
    tun_sq_side_t      sb_in;
    logic              v_in;

    if (j == 0) begin : g_first
      assign n_in  = SQRT_W'(rad_i);
      assign r_in  = '0;
      assign sb_in = sb_i;
      assign v_in  = vld_i;
    end else begin : g_next
      assign n_in  = n_q[j-1];
      assign r_in  = r_q[j-1];
      assign sb_in = sb_q[j-1];
      assign v_in  = v_q[j-1];
    end

    assign bt    = SQRT_W'(1) << (2 * (SQRT_ITER - 1 - j));
    assign trial = r_in + bt;

    always_comb begin
      if (n_in >= trial) begin
        n_d = n_in - trial;
        r_d = (r_in >> 1) + bt;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[j]  <= n_d;
        r_q[j]  <= r_d;
        sb_q[j] <= sb_in;
      end
    end
  end

  assign vld_o  = v_q[SQRT_ITER-1];
  assign root_o = ROOT_W'(r_q[SQRT_ITER-1]);
  assign sb_o   = sb_q[SQRT_ITER-1];

endmodule

// ===== hdl/tun_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tun_div
// Three-lane pipelined restoring divider with round-half-up dividend.
// ---------------------------------------------------------------------------
module tun_div #(
  parameter int unsigned QW = tun_pkg::NORMAL_FRAC_BITS_DEF + 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             vld_i,
  input  logic [2:0][tun_pkg::MT_W-1:0]    mt_i,
  input  logic [tun_pkg::ROOT_W-1:0]       root_i,
  input  tun_pkg::tun_side_t               sb_i,
  output logic                             vld_o,
  output logic [2:0][QW-1:0]               quo_o,
  output tun_pkg::tun_side_t               sb_o
);
  import tun_pkg::*;

  localparam int unsigned DW = QW + 33;

  logic [2:0][DW-1:0] rem_q [QW];
  logic [2:0][QW-1:0] quo_q [QW];
  logic [DW-1:0]      dv_q  [QW];
  tun_side_t          sb_q  [QW];
  logic [QW-1:0]      v_q;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [2:0][DW-1:0] rem_in, rem_d;
    logic [2:0][QW-1:0] quo_in, quo_d;
    logic [DW-1:0]      dv_in, trial;
    tun_side_t          sb_in;
    logic               v_in;

    if (j == 0) begin : g_first
      for (genvar l = 0; l < 3; l++) begin : g_lane
        // 2*m*2^F + R over divisor 2R
        assign rem_in[l] = (DW'(mt_i[l]) << QW) + DW'(root_i);
      end
      assign quo_in = '0;
      assign dv_in  = DW'(root_i) << 1;
      assign sb_in  = sb_i;
      assign v_in   = vld_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign dv_in  = dv_q[j-1];
      assign sb_in  = sb_q[j-1];
      assign v_in   = v_q[j-1];
    end

    assign trial = dv_in << (QW - 1 - j);

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= trial) begin
          rem_d[l] = rem_in[l] - trial;
          quo_d[l] = {quo_in[l][QW-2:0], 1'b1};
        end else begin
          rem_d[l] = rem_in[l];
          quo_d[l] = {quo_in[l][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        quo_q[j] <= quo_d;
        dv_q[j]  <= dv_in;
        sb_q[j]  <= sb_in;
      end
    end
  end

  assign vld_o = v_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle unit normal testbench
// Drives triangles through the valid/ready input and predicts each unit
// normal in software: exact edges and cross product (products kept mod 2^64
// as the datapath does), mantissa scaling, integer square root and rounded
// division. Each output transaction is checked field by field, in order.
// ---------------------------------------------------------------------------
module testbench;
  import tun_pkg::*;

  localparam int unsigned FRAC  = NORMAL_FRAC_BITS_DEF;
  localparam int unsigned LAT   = 44 + FRAC;

  typedef struct {
    logic [IN_W-1:0] c[9];   // v0 xyz, v1 xyz, v2 xyz
    logic            last;
  } tri_t;

  typedef struct {
    logic [OUT_W-1:0] nx, ny, nz;
    logic             dg, last;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, out_ready = 1'b0;
  logic [IN_W-1:0] coord[9];
  logic last_in = 1'b0;
  logic in_ready, out_valid, degenerate, last_out;
  logic signed [OUT_W-1:0] normal_x, normal_y, normal_z;

  normal_t expected_normals[$];
  int  errors = 0;
  bit  send_quiet = 1'b0;   // no idle gaps on the input side
  bit  recv_quiet = 1'b0;   // no stalls on the output side
  bit  hold_req   = 1'b0;   // request a long output stall

  initial for (int i = 0; i < 9; i++) coord[i] = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  triangle_unit_normal u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .v0_x_i(coord[0]), .v0_y_i(coord[1]), .v0_z_i(coord[2]),
    .v1_x_i(coord[3]), .v1_y_i(coord[4]), .v1_z_i(coord[5]),
    .v2_x_i(coord[6]), .v2_y_i(coord[7]), .v2_z_i(coord[8]),
    .last_in_i(last_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .normal_z_o(normal_z),
    .degenerate_o(degenerate), .last_out_o(last_out)
  );

  // ---- prediction --------------------------------------------------------

  // Sign-magnitude product; the magnitude wraps at 64 bits like the datapath.
  function automatic void edge_product(longint a, longint b, output bit ng,
                                       output logic [127:0] mg);
    logic [127:0] ma, mb, full;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    full = ma * mb;
    mg = {64'd0, full[63:0]};
    ng = (mg != 0) && ((a < 0) != (b < 0));
  endfunction

  // x - y on sign-magnitude operands.
  function automatic void sm_sub(bit xn, logic [127:0] xm, bit yn, logic [127:0] ym,
                                 output bit rn, output logic [127:0] rm);
    yn = !yn;
    if (xn == yn) begin
      rm = xm + ym;
      rn = xn;
    end else if (xm >= ym) begin
      rm = xm - ym;
      rn = xn;
    end else begin
      rm = ym - xm;
      rn = yn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(tri_t tr);
    longint a[3], b[3];
    bit pn0, pn1, cn[3];
    logic [127:0] pm0, pm1, cm[3], num, q;
    logic [63:0] m[3], s, r;
    int len, k, t, l;
    normal_t res;
    logic [OUT_W-1:0] o[3];
    for (int i = 0; i < 3; i++) begin
      a[i] = longint'(signed'(tr.c[3+i])) - longint'(signed'(tr.c[i]));
      b[i] = longint'(signed'(tr.c[6+i])) - longint'(signed'(tr.c[i]));
    end
    edge_product(a[1], b[2], pn0, pm0); edge_product(a[2], b[1], pn1, pm1);
    sm_sub(pn0, pm0, pn1, pm1, cn[0], cm[0]);
    edge_product(a[2], b[0], pn0, pm0); edge_product(a[0], b[2], pn1, pm1);
    sm_sub(pn0, pm0, pn1, pm1, cn[1], cm[1]);
    edge_product(a[0], b[1], pn0, pm0); edge_product(a[1], b[0], pn1, pm1);
    sm_sub(pn0, pm0, pn1, pm1, cn[2], cm[2]);
    len = 0;
    for (int i = 0; i < 3; i++) begin
      l = 0;
      for (int j = 0; j < 128; j++) if (cm[i][j]) l = j + 1;
      if (l > len) len = l;
    end
    res.last = tr.last;
    if (len == 0) begin
      res.nx = 0; res.ny = 0; res.nz = 0; res.dg = 1'b1;
      return res;
    end
    k = (len > MANT_BITS) ? len - MANT_BITS : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 64'(cm[i] >> k);
      s += m[i] * m[i];
    end
    t = 0;
    while (s < (64'd1 << 60)) begin
      s <<= 2;
      t++;
    end
    r = int_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      num = 128'(m[i]) << (FRAC + t);
      q = (2 * num + r) / (2 * 128'(r));
      if (q > OUT_MAX) q = OUT_MAX;
      o[i] = cn[i] ? -q[OUT_W-1:0] : q[OUT_W-1:0];
    end
    res.nx = o[0]; res.ny = o[1]; res.nz = o[2]; res.dg = 1'b0;
    return res;
  endfunction

  // ---- driver ------------------------------------------------------------

  // Predict from the port values at the accepting edge.
  always @(posedge clk) begin
    tri_t seen;
    if (rst_n && in_valid && in_ready) begin
      for (int i = 0; i < 9; i++) seen.c[i] = coord[i];
      seen.last = last_in;
      expected_normals.insert(expected_normals.size(), face_normal(seen));
    end
  end

  task automatic send_triangle(tri_t tr);
    if (!send_quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) coord[i] <= tr.c[i];
    last_in  <= tr.last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_coords(logic [IN_W-1:0] c0, c1, c2, c3, c4, c5, c6, c7, c8,
                             logic lst);
    tri_t tr;
    tr.c = '{c0, c1, c2, c3, c4, c5, c6, c7, c8};
    tr.last = lst;
    send_triangle(tr);
  endtask

  // ---- receiver and checker ----------------------------------------------

  int hold_cnt = 0;
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= 300;
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
      if (hold_cnt == 1) hold_req <= 1'b0;
    end else begin
      out_ready <= recv_quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, normal_x, normal_y,
                 normal_z);
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (normal_x !== e.nx) begin
          $display("%0t: normal_x exp %h got %h", $time, e.nx, normal_x); errors++;
        end
        if (normal_y !== e.ny) begin
          $display("%0t: normal_y exp %h got %h", $time, e.ny, normal_y); errors++;
        end
        if (normal_z !== e.nz) begin
          $display("%0t: normal_z exp %h got %h", $time, e.nz, normal_z); errors++;
        end
        if (degenerate !== e.dg) begin
          $display("%0t: degenerate exp %b got %b", $time, e.dg, degenerate); errors++;
        end
        if (last_out !== e.last) begin
          $display("%0t: last_out exp %b got %b", $time, e.last, last_out); errors++;
        end
      end
    end
  end

  // ---- tests -------------------------------------------------------------

  localparam logic [31:0] MAXC = 32'h7fff_ffff, MINC = 32'h8000_0000, ONE = 32'h0001_0000;

  // Extremes, axis-aligned faces, degenerate shapes, wrapping products.
  task automatic test_directed();
    send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);                 // all zero
    send_coords(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 1'b1);             // +z face
    send_coords(0, 0, 0, 0, ONE, 0, ONE, 0, 0, 1'b0);             // -z face
    send_coords(0, 0, 0, 0, ONE, 0, 0, 0, ONE, 1'b0);             // +x face
    send_coords(0, 0, 0, 0, 0, ONE, ONE, 0, 0, 1'b0);             // +y face
    send_coords(ONE, ONE, ONE, ONE, ONE, ONE, 5, 6, 7, 1'b0);     // repeated vertex
    send_coords(0, 0, 0, 1, 2, 3, 2, 4, 6, 1'b1);                 // collinear
    send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0);                 // tiniest face
    send_coords(1, 1, 1, 1, 1, 1, 1, 1, 1, 1'b0);
    send_coords(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MINC, 1'b0);
    send_coords(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MAXC, 1'b0);
    send_coords(MINC, MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, 1'b0);
    send_coords(MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MINC, 1'b1);
    send_coords(MINC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MINC, 1'b0);
    send_coords(32'hffff_ffff, 0, 32'h1234_5678, MAXC, 32'h8765_4321, MINC,
                32'haaaa_aaaa, 32'h5555_5555, 0, 1'b0);
    send_coords(0, 0, 0, ONE, ONE, ONE, ONE, ONE, 32'h0001_0001, 1'b0); // sliver
  endtask

  function automatic logic [31:0] rand_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8191)) - 4096) <<< 12;
      2: return $urandom_range(1) ? MAXC - $urandom_range(3) : MINC + $urandom_range(3);
      default: return 32'($signed($urandom_range(0, 64)) - 32);
    endcase
  endfunction

  task automatic test_random(int count);
    tri_t tr;
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(3);
      for (int i = 0; i < 9; i++) tr.c[i] = rand_coord($urandom_range(9) == 0 ? 0 : kind);
      case ($urandom_range(15))
        0: for (int i = 0; i < 3; i++) tr.c[3+i] = tr.c[i];       // repeated vertex
        1: for (int i = 0; i < 3; i++) tr.c[6+i] = tr.c[3+i];
        default: ;
      endcase
      tr.last = ($urandom_range(7) == 0);
      send_triangle(tr);
    end
  endtask

  // Output held off long enough that the pipeline fills and stalls the input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_quiet = 1'b1;
    test_random(150);
    send_quiet = 1'b0;
  endtask

  task automatic test_no_idling();
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    test_random(250);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500);
    test_backpressure();
    test_no_idling();
    test_random(550);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_normals.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tun_pkg.sv
hdl/tun_sqrt.sv
hdl/tun_div.sv
hdl/triangle_unit_normal.sv
verif/testbench.sv
